>>> rtl/core/text_console_cursor_scroll_top_macros.svh
// Assertion helpers shared by the console RTL.
// Both expect clk and rst_n in scope.
`ifndef TEXT_CONSOLE_CURSOR_SCROLL_TOP_MACROS_SVH
`define TEXT_CONSOLE_CURSOR_SCROLL_TOP_MACROS_SVH

// Same-cycle implication
`define TTC_ASSERT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define TTC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/ttc_pkg.sv
`timescale 1ns / 1ps
package ttc_pkg;

    localparam int COLUMNS_DEF = 80;
    localparam int ROWS_DEF    = 25;
    localparam int COL_W       = 7;
    localparam int ROW_W       = 5;
    localparam int CELL_W      = 16;
    localparam int CHAR_W      = 8;
    localparam int COLOR_W     = 4;
    localparam int NUM_W       = 32;
    localparam int OP_W        = 3;
    localparam int DIG_N       = 10;   // decimal digits of a 32-bit value
    localparam int QUEUE_DEPTH = 2;

    localparam logic [COLOR_W-1:0] TEXT_FG_RST = 4'hB;
    localparam logic [COLOR_W-1:0] TEXT_BG_RST = 4'h0;

    typedef enum logic [OP_W-1:0] {
        OP_PUT     = 3'd0,
        OP_NEWLINE = 3'd1,
        OP_POKE    = 3'd2,
        OP_DEC     = 3'd3,
        OP_HEX     = 3'd4,
        OP_PEEK    = 3'd5,
        OP_CLEAR   = 3'd6,
        OP_NONE    = 3'd7
    } op_t;

    typedef enum logic {
        REG_TEXT_FG = 1'b0,
        REG_TEXT_BG = 1'b1
    } cfg_reg_t;

    // Classified command handed from front to back
    typedef struct packed {
        op_t                op;
        logic [CELL_W-1:0]  cell_word; // full cell, or digit colours in 15:8
        logic [COL_W-1:0]   col;
        logic [ROW_W-1:0]   row;
        logic               in_range;
        logic [NUM_W-1:0]   number;
    } cmd_t;

    function automatic logic [CELL_W-1:0] make_cell(
        input logic [CHAR_W-1:0]  ch,
        input logic [COLOR_W-1:0] fg,
        input logic [COLOR_W-1:0] bg
    );
        return {bg, fg, ch};
    endfunction

    // Digit value to ASCII, uppercase hex
    function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d);
        if (d < 4'd10)
            return 8'h30 + {4'h0, d};
        else
            return 8'h37 + {4'h0, d};
    endfunction

endpackage

>>> rtl/core/ttc_if.sv
`timescale 1ns / 1ps
// Command channel
interface ttc_cmd_if;
    import ttc_pkg::*;
    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     operation;
    logic [CHAR_W-1:0]   char_code;
    logic [COLOR_W-1:0]  fg_color;
    logic [COLOR_W-1:0]  bg_color;
    logic [COL_W-1:0]    column;
    logic [ROW_W-1:0]    row;
    logic [NUM_W-1:0]    number;
    modport source (output valid, operation, char_code, fg_color, bg_color, column, row,
                    number, input ready);
    modport sink   (input valid, operation, char_code, fg_color, bg_color, column, row,
                    number, output ready);
endinterface

// Result channel
interface ttc_rsp_if;
    import ttc_pkg::*;
    logic                valid;
    logic                ready;
    logic [CELL_W-1:0]   cell_value;
    logic [COL_W-1:0]    cursor_column;
    logic [ROW_W-1:0]    cursor_row;
    logic                scrolled;
    modport source (output valid, cell_value, cursor_column, cursor_row, scrolled,
                    input ready);
    modport sink   (input valid, cell_value, cursor_column, cursor_row, scrolled,
                    output ready);
endinterface

// Register write channel
interface ttc_cfg_if;
    import ttc_pkg::*;
    logic                valid;
    logic                ready;
    logic                index;
    logic [COLOR_W-1:0]  data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/core/text_console_cursor_scroll_top.sv
`timescale 1ns / 1ps
// Text console, COLUMNS x ROWS cells of 16 bits (char 7:0, fg 11:8, bg 15:12).
// cmd: one item per operation (put, newline, positioned write, decimal or hex
//   number, cell read, clear); accepted when valid and ready are high.
// rsp: exactly one result item per command: read cell, cursor, scroll flag.
// cfg: index 0 sets the digit foreground, index 1 the digit background.
// Commands enter a two-item queue and are executed by a sequencer around
// a screen RAM with one write and one registered read port; scrolling moves
// a row offset and blanks one row.
// The sequencer carries each command through to the result register before
// it takes the next one from the queue; every scroll blanks a row, one
// blanked cell per cycle.
// After reset the RAM is swept to zero; cmd.ready stays low meanwhile,
// register writes are still taken.
// A result waits in the output register while rsp.ready is low; the queue
// keeps taking commands until it is full, then cmd.ready drops.
module text_console_cursor_scroll_top #(
    parameter int COLUMNS = ttc_pkg::COLUMNS_DEF,
    parameter int ROWS    = ttc_pkg::ROWS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    ttc_cmd_if.sink   cmd,
    ttc_rsp_if.source rsp,
    ttc_cfg_if.sink   cfg
);
    import ttc_pkg::*;

    cmd_t q_wdata;
    cmd_t q_rdata;
    logic q_push;
    logic q_pop;
    logic q_full;
    logic q_empty;
    logic init_busy;

    ttc_front #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cfg       (cfg),
        .init_busy (init_busy),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_data    (q_wdata)
    );

    ttc_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .pop   (q_pop),
        .rdata (q_rdata),
        .full  (q_full),
        .empty (q_empty)
    );

    ttc_back #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_data    (q_rdata),
        .q_valid   (!q_empty),
        .q_pop     (q_pop),
        .init_busy (init_busy),
        .rsp       (rsp)
    );

endmodule

>>> rtl/core/ttc_front.sv
`timescale 1ns / 1ps
module ttc_front #(
    parameter int COLUMNS = ttc_pkg::COLUMNS_DEF,
    parameter int ROWS    = ttc_pkg::ROWS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    ttc_cmd_if.sink       cmd,
    ttc_cfg_if.sink       cfg,
    input  logic          init_busy,
    input  logic          q_full,
    output logic          q_push,
    output ttc_pkg::cmd_t q_data
);
    import ttc_pkg::*;

    logic [COLOR_W-1:0] text_fg_reg;
    logic [COLOR_W-1:0] text_bg_reg;

    // Digit colour registers
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_fg_reg <= TEXT_FG_RST;
            text_bg_reg <= TEXT_BG_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg_reg_t'(cfg.index))
                REG_TEXT_FG: text_fg_reg <= cfg.data;
                REG_TEXT_BG: text_bg_reg <= cfg.data;
            endcase
        end
    end

    // Accept while the queue has room and the power-up clear is done
    assign cmd.ready = !q_full && !init_busy;
    assign q_push    = cmd.valid && cmd.ready;

    // Classify the item
    always_comb
    begin
        q_data.op       = op_t'(cmd.operation);
        q_data.col      = cmd.column;
        q_data.row      = cmd.row;
        q_data.number   = cmd.number;
        q_data.in_range = (int'(cmd.column) < COLUMNS) && (int'(cmd.row) < ROWS);
        priority if (q_data.op == OP_DEC || q_data.op == OP_HEX)
            q_data.cell_word = make_cell(8'h00, text_fg_reg, text_bg_reg);
        else
            q_data.cell_word = make_cell(cmd.char_code, cmd.fg_color, cmd.bg_color);
    end

endmodule

>>> rtl/core/ttc_fifo.sv
`timescale 1ns / 1ps
module ttc_fifo #(
    parameter int DEPTH = ttc_pkg::QUEUE_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  ttc_pkg::cmd_t wdata,
    input  logic          pop,
    output ttc_pkg::cmd_t rdata,
    output logic          full,
    output logic          empty
);
    import ttc_pkg::*;
    `include "text_console_cursor_scroll_top_macros.svh"

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t               slot_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign rdata = slot_reg[rd_ptr_reg];

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= wdata;
    end

    // Pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    `TTC_ASSERT(a_fill_bound, 1'b1, count_reg <= CNT_W'(DEPTH), "queue overfilled")
    `TTC_ASSERT(a_pop_nonempty, pop, !empty, "pop from empty queue")
    `TTC_ASSERT_NEXT(a_fill_up, push && !pop, count_reg == $past(count_reg) + 1'b1,
        "fill level did not rise")

endmodule

>>> rtl/core/ttc_back.sv
`timescale 1ns / 1ps
module ttc_back #(
    parameter int COLUMNS = ttc_pkg::COLUMNS_DEF,
    parameter int ROWS    = ttc_pkg::ROWS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  ttc_pkg::cmd_t q_data,
    input  logic          q_valid,
    output logic          q_pop,
    output logic          init_busy,
    ttc_rsp_if.source     rsp
);
    import ttc_pkg::*;
    `include "text_console_cursor_scroll_top_macros.svh"

    localparam int DEPTH     = COLUMNS * ROWS;
    localparam int AW        = $clog2(DEPTH);
    localparam int BCD_W     = 4 * DIG_N;
    localparam int DIG_IDX_W = $clog2(DIG_N);
    localparam int BIT_W     = $clog2(NUM_W);

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_PEEK, S_CONV, S_LEAD, S_EMIT, S_SCROLL, S_DONE
    } state_t;

    state_t                 state_reg;
    logic [COL_W-1:0]       col_reg;
    logic [ROW_W-1:0]       row_reg;
    logic [ROW_W-1:0]       top_reg;       // physical row shown as row 0
    logic                   scrolled_reg;
    logic [CELL_W-1:0]      cell_reg;
    logic [CELL_W-1:0]      colour_reg;
    logic [NUM_W-1:0]       bin_reg;
    logic [BCD_W-1:0]       bcd_reg;
    logic [BIT_W-1:0]       bit_cnt_reg;
    logic [DIG_IDX_W-1:0]   dig_idx_reg;
    logic [AW-1:0]          clr_cnt_reg;
    logic [AW-1:0]          scroll_base_reg;
    logic                   ret_emit_reg;
    logic                   clr_cmd_reg;
    logic                   out_valid_reg;
    logic [CELL_W-1:0]      out_cell_reg;
    logic [COL_W-1:0]       out_col_reg;
    logic [ROW_W-1:0]       out_row_reg;
    logic                   out_scrolled_reg;

    logic [CELL_W-1:0]      screen_mem [DEPTH];
    logic [CELL_W-1:0]      rdata_reg;

    logic                   mem_we;
    logic [AW-1:0]          mem_waddr;
    logic [CELL_W-1:0]      mem_wdata;
    logic [AW-1:0]          cursor_addr;
    logic [AW-1:0]          pos_addr;
    logic [BCD_W-1:0]       bcd_adj;
    logic [DIG_IDX_W-1:0]   lead_idx;
    logic [3:0]             cur_digit;
    logic                   last_col;
    logic                   last_row;
    logic                   out_free;

    // Logical row to physical row through the scroll offset
    function automatic logic [ROW_W-1:0] phys_row(
        input logic [ROW_W-1:0] r,
        input logic [ROW_W-1:0] t
    );
        logic [ROW_W:0] s;
        s = {1'b0, r} + {1'b0, t};
        if (s >= (ROW_W+1)'(ROWS))
            s = s - (ROW_W+1)'(ROWS);
        return s[ROW_W-1:0];
    endfunction

    assign cursor_addr = AW'(int'(phys_row(row_reg, top_reg)) * COLUMNS + int'(col_reg));
    assign pos_addr    = AW'(int'(phys_row(q_data.row, top_reg)) * COLUMNS
                             + int'(q_data.col));
    assign last_col    = (col_reg == COL_W'(COLUMNS - 1));
    assign last_row    = (row_reg == ROW_W'(ROWS - 1));
    assign cur_digit   = bcd_reg[{dig_idx_reg, 2'b00} +: 4];
    assign out_free    = !out_valid_reg || rsp.ready;
    assign q_pop       = (state_reg == S_IDLE) && q_valid;
    assign init_busy   = (state_reg == S_CLEAR) && !clr_cmd_reg;

    // Double-dabble correction, one per BCD digit
    always_comb
    begin
        bcd_adj = bcd_reg;
        for (int i = 0; i < DIG_N; i++)
        begin
            if (bcd_reg[i*4 +: 4] >= 4'd5)
                bcd_adj[i*4 +: 4] = bcd_reg[i*4 +: 4] + 4'd3;
        end
    end

    // Most significant non-zero digit, zero prints one digit
    always_comb
    begin
        lead_idx = '0;
        for (int i = 0; i < DIG_N; i++)
        begin
            if (bcd_reg[i*4 +: 4] != 4'd0)
                lead_idx = DIG_IDX_W'(i);
        end
    end

    // Screen write port
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = cursor_addr;
        mem_wdata = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_cnt_reg;
            end
            S_SCROLL:
            begin
                mem_we    = 1'b1;
                mem_waddr = scroll_base_reg + clr_cnt_reg;
            end
            S_EMIT:
            begin
                mem_we    = 1'b1;
                mem_wdata = {colour_reg[15:8], digit_char(cur_digit)};
            end
            S_IDLE:
            begin
                if (q_valid && q_data.op == OP_PUT)
                begin
                    mem_we    = 1'b1;
                    mem_wdata = q_data.cell_word;
                end
                else if (q_valid && q_data.op == OP_POKE && q_data.in_range)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = pos_addr;
                    mem_wdata = q_data.cell_word;
                end
            end
            default: ;
        endcase
    end

    // Screen store
    always_ff @(posedge clk)
    begin
        if (mem_we)
            screen_mem[mem_waddr] <= mem_wdata;
        rdata_reg <= screen_mem[pos_addr];
    end

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_CLEAR;
            col_reg          <= '0;
            row_reg          <= '0;
            top_reg          <= '0;
            scrolled_reg     <= 1'b0;
            clr_cnt_reg      <= '0;
            clr_cmd_reg      <= 1'b0;
            ret_emit_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            // S_DONE loads the result register itself
            if (rsp.ready && state_reg != S_DONE)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (clr_cnt_reg == AW'(DEPTH - 1))
                        state_reg <= clr_cmd_reg ? S_DONE : S_IDLE;
                end

                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        scrolled_reg <= (q_data.op == OP_PUT && last_col && last_row)
                                        || (q_data.op == OP_NEWLINE && last_row);
                        cell_reg     <= '0;
                        colour_reg   <= q_data.cell_word;
                        unique case (q_data.op)
                            OP_PUT:
                            begin
                                col_reg <= last_col ? '0 : col_reg + 1'b1;
                                if (last_col && last_row)
                                begin
                                    scroll_base_reg <= AW'(int'(top_reg) * COLUMNS);
                                    top_reg <= (top_reg == ROW_W'(ROWS - 1)) ? '0
                                                                             : top_reg + 1'b1;
                                    clr_cnt_reg  <= '0;
                                    ret_emit_reg <= 1'b0;
                                    state_reg    <= S_SCROLL;
                                end
                                else
                                begin
                                    if (last_col)
                                        row_reg <= row_reg + 1'b1;
                                    state_reg <= S_DONE;
                                end
                            end
                            OP_NEWLINE:
                            begin
                                col_reg <= '0;
                                if (last_row)
                                begin
                                    scroll_base_reg <= AW'(int'(top_reg) * COLUMNS);
                                    top_reg <= (top_reg == ROW_W'(ROWS - 1)) ? '0
                                                                             : top_reg + 1'b1;
                                    clr_cnt_reg  <= '0;
                                    ret_emit_reg <= 1'b0;
                                    state_reg    <= S_SCROLL;
                                end
                                else
                                begin
                                    row_reg   <= row_reg + 1'b1;
                                    state_reg <= S_DONE;
                                end
                            end
                            OP_POKE:
                                state_reg <= S_DONE;
                            OP_DEC:
                            begin
                                bin_reg     <= q_data.number;
                                bcd_reg     <= '0;
                                bit_cnt_reg <= '0;
                                state_reg   <= S_CONV;
                            end
                            OP_HEX:
                            begin
                                bcd_reg   <= BCD_W'(q_data.number);
                                state_reg <= S_LEAD;
                            end
                            OP_PEEK:
                                state_reg <= q_data.in_range ? S_PEEK : S_DONE;
                            OP_CLEAR:
                            begin
                                col_reg     <= '0;
                                row_reg     <= '0;
                                top_reg     <= '0;
                                clr_cnt_reg <= '0;
                                clr_cmd_reg <= 1'b1;
                                state_reg   <= S_CLEAR;
                            end
                            OP_NONE:
                                state_reg <= S_DONE;
                        endcase
                    end
                end

                S_PEEK:
                begin
                    cell_reg  <= rdata_reg;
                    state_reg <= S_DONE;
                end

                // Binary to BCD, one bit a cycle
                S_CONV:
                begin
                    {bcd_reg, bin_reg} <= {bcd_adj, bin_reg} << 1;
                    bit_cnt_reg <= bit_cnt_reg + 1'b1;
                    if (bit_cnt_reg == BIT_W'(NUM_W - 1))
                        state_reg <= S_LEAD;
                end

                S_LEAD:
                begin
                    dig_idx_reg <= lead_idx;
                    state_reg   <= S_EMIT;
                end

                // One digit written and the cursor advanced per cycle, paused while a scroll runs
                S_EMIT:
                begin
                    dig_idx_reg <= dig_idx_reg - 1'b1;
                    col_reg     <= last_col ? '0 : col_reg + 1'b1;
                    if (last_col && last_row)
                    begin
                        scroll_base_reg <= AW'(int'(top_reg) * COLUMNS);
                        top_reg <= (top_reg == ROW_W'(ROWS - 1)) ? '0 : top_reg + 1'b1;
                        clr_cnt_reg  <= '0;
                        scrolled_reg <= 1'b1;
                        ret_emit_reg <= (dig_idx_reg != '0);
                        state_reg    <= S_SCROLL;
                    end
                    else
                    begin
                        if (last_col)
                            row_reg <= row_reg + 1'b1;
                        if (dig_idx_reg == '0)
                            state_reg <= S_DONE;
                    end
                end

                // Blank the row that came in at the bottom
                S_SCROLL:
                begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (clr_cnt_reg == AW'(COLUMNS - 1))
                        state_reg <= ret_emit_reg ? S_EMIT : S_DONE;
                end

                S_DONE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg    <= 1'b1;
                        out_cell_reg     <= cell_reg;
                        out_col_reg      <= col_reg;
                        out_row_reg      <= row_reg;
                        out_scrolled_reg <= scrolled_reg;
                        clr_cmd_reg      <= 1'b0;
                        state_reg        <= S_IDLE;
                    end
                end
            endcase
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.cell_value    = out_cell_reg;
    assign rsp.cursor_column = out_col_reg;
    assign rsp.cursor_row    = out_row_reg;
    assign rsp.scrolled      = out_scrolled_reg;

    `TTC_ASSERT(a_cursor_range, 1'b1,
        (int'(col_reg) < COLUMNS) && (int'(row_reg) < ROWS), "cursor off screen")
    `TTC_ASSERT(a_scroll_flag, state_reg == S_SCROLL, scrolled_reg, "scroll not flagged")
    `TTC_ASSERT_NEXT(a_pop_moves, q_pop, state_reg != S_IDLE, "command not taken up")
    `TTC_ASSERT(a_write_range, mem_we, int'(mem_waddr) < DEPTH, "screen write out of range")

endmodule
